// ----- hw/rtl/itrs_pkg.sv -----
// Shared types, codes and sizes for the I2C register transfer sequencer.
package itrs_pkg;

  localparam int MAX_BYTES = 16;
  localparam int IDX_W     = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
  localparam int LEN_W     = $clog2(MAX_BYTES + 1);

  typedef enum logic [1:0] {
    OP_EVENT = 2'd0,
    OP_REQ   = 2'd1,
    OP_LOAD  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_CMD  = 2'd0,
    KIND_DATA = 2'd1,
    KIND_ERR  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    CMD_START = 3'd0,
    CMD_STOP  = 3'd1,
    CMD_TX    = 3'd2,
    CMD_RX_EN = 3'd3,
    CMD_ACK   = 3'd4
  } cmd_t;

  typedef enum logic [3:0] {
    PH_WAITING   = 4'd0,
    PH_STARTING  = 4'd1,
    PH_SEL_DEV   = 4'd2,
    PH_SEL_REG   = 4'd3,
    PH_WRITING   = 4'd4,
    PH_SHORTSTOP = 4'd5,
    PH_RESTART   = 4'd6,
    PH_RESEL_DEV = 4'd7,
    PH_READING   = 4'd8,
    PH_FIN_ACK   = 4'd9,
    PH_STOPPING  = 4'd10
  } phase_t;

  typedef enum logic {
    SEQ_IDLE = 1'b0,
    SEQ_EMIT = 1'b1
  } seq_t;

  typedef struct packed {
    op_t        op;
    logic       is_write;
    logic [6:0] device_address;
    logic [7:0] register_address;
    logic [4:0] length;
    logic       start_busy;
    logic       stop_busy;
    logic       ack_busy;
    logic       ack_received;
    logic       rx_full;
    logic [7:0] data_byte;
    logic [3:0] write_index;
  } in_item_t;

  typedef struct packed {
    kind_t      kind;
    cmd_t       command;
    logic [7:0] byte_value;
    logic       ack_value;
    logic       last;
  } res_t;

  typedef struct packed {
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [7:0]       wr_data;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
  } buf_req_t;

endpackage

// ----- hw/rtl/itrs_buf.sv -----
// Byte buffer: one write port, one registered read port, per-entry valid bits.
module itrs_buf (
  input  logic               clk,
  input  logic               rst_n,
  input  itrs_pkg::buf_req_t req,
  output logic [7:0]         rd_data
);
  import itrs_pkg::*;

  logic [7:0]           mem [MAX_BYTES];
  logic [MAX_BYTES-1:0] vld_r;
  logic [7:0]           rd_data_r;
  logic                 rd_vld_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  // unwritten entries read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (req.wr_en) begin
        vld_r[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_vld_r <= vld_r[req.rd_addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_data_r : 8'd0;

endmodule

// ----- hw/rtl/itrs_ctrl.sv -----
// Transfer sequencer: bus phase machine, counters and result beat issue.
module itrs_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  itrs_pkg::in_item_t item,
  output logic               busy,
  output logic               res_valid,
  output itrs_pkg::res_t     res,
  input  logic               res_ready,
  output itrs_pkg::buf_req_t buf_req,
  input  logic [7:0]         rd_data
);
  import itrs_pkg::*;

  seq_t             seq_r, seq_nxt;
  phase_t           phase_r, phase_nxt;
  logic [6:0]       addr_r, addr_nxt;
  logic [7:0]       reg_r, reg_nxt;
  logic             dir_r, dir_nxt;
  logic [LEN_W-1:0] rx_r, rx_nxt;
  logic [LEN_W-1:0] tx_r, tx_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [IDX_W-1:0] k_r, k_nxt;
  res_t             pend_r, pend_nxt;
  logic             use_rd_r, use_rd_nxt;
  logic             dump_r, dump_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r    <= SEQ_IDLE;
      phase_r  <= PH_WAITING;
      addr_r   <= '0;
      reg_r    <= '0;
      dir_r    <= 1'b0;
      rx_r     <= '0;
      tx_r     <= '0;
      len_r    <= '0;
      k_r      <= '0;
      use_rd_r <= 1'b0;
      dump_r   <= 1'b0;
    end else begin
      seq_r    <= seq_nxt;
      phase_r  <= phase_nxt;
      addr_r   <= addr_nxt;
      reg_r    <= reg_nxt;
      dir_r    <= dir_nxt;
      rx_r     <= rx_nxt;
      tx_r     <= tx_nxt;
      len_r    <= len_nxt;
      k_r      <= k_nxt;
      use_rd_r <= use_rd_nxt;
      dump_r   <= dump_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_r <= pend_nxt;
  end

  always_comb begin
    logic             go;
    logic             do_nw;
    logic [LEN_W-1:0] len_v;
    logic [LEN_W-1:0] pos_v;
    logic [LEN_W-1:0] rxm1_v;
    logic [LEN_W:0]   nxt_cnt;

    seq_nxt    = seq_r;
    phase_nxt  = phase_r;
    addr_nxt   = addr_r;
    reg_nxt    = reg_r;
    dir_nxt    = dir_r;
    rx_nxt     = rx_r;
    tx_nxt     = tx_r;
    len_nxt    = len_r;
    k_nxt      = k_r;
    pend_nxt   = pend_r;
    use_rd_nxt = use_rd_r;
    dump_nxt   = dump_r;
    buf_req    = '0;
    go         = 1'b0;
    do_nw      = 1'b0;
    len_v      = '0;
    pos_v      = '0;
    rxm1_v     = rx_r - LEN_W'(1);
    nxt_cnt    = {1'b0, LEN_W'(k_r)} + (LEN_W + 1)'(2);
    res_valid  = 1'b0;
    res        = pend_r;
    if (use_rd_r) begin
      res.byte_value = rd_data;
    end

    case (seq_r)
      SEQ_IDLE: begin
        if (in_valid) begin
          res_t r;
          r.kind       = KIND_CMD;
          r.command    = CMD_START;
          r.byte_value = 8'd0;
          r.ack_value  = 1'b0;
          r.last       = 1'b1;
          pend_nxt   = r;
          use_rd_nxt = 1'b0;
          dump_nxt   = 1'b0;
          case (item.op)
            OP_LOAD: begin
              if (int'(item.write_index) < MAX_BYTES) begin
                buf_req.wr_en   = 1'b1;
                buf_req.wr_addr = IDX_W'(item.write_index);
                buf_req.wr_data = item.data_byte;
              end
            end
            OP_REQ: begin
              if (int'(item.length) > MAX_BYTES) begin
                len_v = LEN_W'(MAX_BYTES);
              end else begin
                len_v = LEN_W'(item.length);
              end
              go = 1'b1;
              if (!item.is_write && len_v == '0) begin
                pend_nxt.kind = KIND_ERR;
              end else begin
                dir_nxt   = item.is_write;
                addr_nxt  = item.device_address;
                reg_nxt   = item.register_address;
                len_nxt   = len_v;
                rx_nxt    = item.is_write ? '0 : len_v;
                tx_nxt    = item.is_write ? len_v : '0;
                phase_nxt = PH_STARTING;
              end
            end
            OP_EVENT: begin
              case (phase_r)
                PH_WAITING: begin
                  go = 1'b1;
                  pend_nxt.kind = KIND_ERR;
                end
                PH_STARTING: begin
                  if (!item.start_busy) begin
                    go = 1'b1;
                    phase_nxt = PH_SEL_DEV;
                    pend_nxt.command    = CMD_TX;
                    pend_nxt.byte_value = {addr_r, 1'b0};
                  end
                end
                PH_SEL_DEV: begin
                  if (!item.ack_received) begin
                    go = 1'b1;
                    phase_nxt = PH_SEL_REG;
                    pend_nxt.command    = CMD_TX;
                    pend_nxt.byte_value = reg_r;
                  end
                end
                PH_SEL_REG: begin
                  if (!item.ack_received) begin
                    if (dir_r) begin
                      do_nw = 1'b1;
                    end else begin
                      go = 1'b1;
                      phase_nxt = PH_SHORTSTOP;
                      pend_nxt.command = CMD_STOP;
                    end
                  end
                end
                PH_WRITING: begin
                  if (!item.ack_received) begin
                    do_nw = 1'b1;
                  end
                end
                PH_SHORTSTOP: begin
                  if (!item.stop_busy) begin
                    go = 1'b1;
                    phase_nxt = PH_RESTART;
                    pend_nxt.command = CMD_START;
                  end
                end
                PH_RESTART: begin
                  if (!item.start_busy) begin
                    go = 1'b1;
                    phase_nxt = PH_RESEL_DEV;
                    pend_nxt.command    = CMD_TX;
                    pend_nxt.byte_value = {addr_r, 1'b1};
                  end
                end
                PH_RESEL_DEV: begin
                  if (!item.ack_received) begin
                    go = 1'b1;
                    phase_nxt = PH_READING;
                    pend_nxt.command = CMD_RX_EN;
                  end
                end
                PH_READING: begin
                  if (item.rx_full && rx_r != '0) begin
                    rx_nxt = rxm1_v;
                    // bytes land in reverse order of arrival
                    if (int'(rxm1_v) < MAX_BYTES) begin
                      buf_req.wr_en   = 1'b1;
                      buf_req.wr_addr = IDX_W'(rxm1_v);
                      buf_req.wr_data = item.data_byte;
                    end
                    go = 1'b1;
                    phase_nxt = PH_FIN_ACK;
                    pend_nxt.command   = CMD_ACK;
                    pend_nxt.ack_value = (rxm1_v == '0);
                  end
                end
                PH_FIN_ACK: begin
                  if (!item.ack_busy) begin
                    go = 1'b1;
                    if (rx_r != '0) begin
                      phase_nxt = PH_READING;
                      pend_nxt.command = CMD_RX_EN;
                    end else begin
                      phase_nxt = PH_STOPPING;
                      pend_nxt.command = CMD_STOP;
                    end
                  end
                end
                PH_STOPPING: begin
                  if (!item.stop_busy) begin
                    phase_nxt = PH_WAITING;
                    if (!dir_r && len_r != '0) begin
                      // read-out run, buffer entry 0 first
                      go = 1'b1;
                      buf_req.rd_en   = 1'b1;
                      buf_req.rd_addr = '0;
                      k_nxt           = '0;
                      dump_nxt        = 1'b1;
                      use_rd_nxt      = 1'b1;
                      pend_nxt.kind   = KIND_DATA;
                      pend_nxt.last   = (len_r == LEN_W'(1));
                    end
                  end
                end
                default: begin
                  go = 1'b1;
                  phase_nxt = PH_WAITING;
                  pend_nxt.kind = KIND_ERR;
                end
              endcase

              if (do_nw) begin
                go = 1'b1;
                if (tx_r == '0) begin
                  phase_nxt = PH_STOPPING;
                  pend_nxt.command = CMD_STOP;
                end else begin
                  pos_v           = len_r - tx_r;
                  tx_nxt          = tx_r - LEN_W'(1);
                  phase_nxt       = PH_WRITING;
                  buf_req.rd_en   = 1'b1;
                  buf_req.rd_addr = IDX_W'(pos_v);
                  use_rd_nxt      = 1'b1;
                  pend_nxt.command = CMD_TX;
                end
              end
            end
            default: ;
          endcase
          if (go) begin
            seq_nxt = SEQ_EMIT;
          end
        end
      end
      SEQ_EMIT: begin
        res_valid = 1'b1;
        if (res_ready) begin
          if (dump_r && !pend_r.last) begin
            k_nxt           = k_r + IDX_W'(1);
            buf_req.rd_en   = 1'b1;
            buf_req.rd_addr = k_nxt;
            pend_nxt.last   = (nxt_cnt == {1'b0, len_r});
          end else begin
            seq_nxt = SEQ_IDLE;
          end
        end
      end
      default: seq_nxt = SEQ_IDLE;
    endcase
  end

  assign busy = (seq_r != SEQ_IDLE);

endmodule

// ----- hw/rtl/i2c_register_transfer_sequencer_top.sv -----
// Top level of the I2C register transfer sequencer: ports, output register, checks.
// An item that gives a result has its first beat held in the sequencer, then taken
//   into the output register once it is free; items with no result leave the sequencer idle.
// No item is taken while a result beat is pending; a read-out run adds one beat per
//   cycle unless stalled, up to MAX_BYTES beats, paced by the single buffer read port.
// Reset (synchronous, rst_n low): phase to waiting, counters and output valid cleared,
//   buffer valid bits cleared so every entry reads as zero.
module i2c_register_transfer_sequencer_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_op,
  input  logic       in_is_write,
  input  logic [6:0] in_device_address,
  input  logic [7:0] in_register_address,
  input  logic [4:0] in_length,
  input  logic       in_start_busy,
  input  logic       in_stop_busy,
  input  logic       in_ack_busy,
  input  logic       in_ack_received,
  input  logic       in_rx_full,
  input  logic [7:0] in_data_byte,
  input  logic [3:0] in_write_index,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_kind,
  output logic [2:0] out_command,
  output logic [7:0] out_byte_value,
  output logic       out_ack_value,
  output logic       out_last
);
  import itrs_pkg::*;

  in_item_t   item;
  buf_req_t   buf_req;
  logic [7:0] rd_data;
  logic       busy;
  logic       res_valid;
  logic       res_ready;
  res_t       res;
  logic       out_valid_r;
  res_t       out_r;

  // payload bundle for the sequencer
  assign item.op               = op_t'(in_op);
  assign item.is_write         = in_is_write;
  assign item.device_address   = in_device_address;
  assign item.register_address = in_register_address;
  assign item.length           = in_length;
  assign item.start_busy       = in_start_busy;
  assign item.stop_busy        = in_stop_busy;
  assign item.ack_busy         = in_ack_busy;
  assign item.ack_received     = in_ack_received;
  assign item.rx_full          = in_rx_full;
  assign item.data_byte        = in_data_byte;
  assign item.write_index      = in_write_index;

  itrs_buf u_buf (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (buf_req),
    .rd_data (rd_data)
  );

  itrs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .item      (item),
    .busy      (busy),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready),
    .buf_req   (buf_req),
    .rd_data   (rd_data)
  );

  // sequencer takes items only between transfers of result beats
  assign in_stall = busy;

  // output register: refills in the same cycle the held beat leaves
  assign res_ready = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_r <= res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = out_r.kind;
  assign out_command    = out_r.command;
  assign out_byte_value = out_r.byte_value;
  assign out_ack_value  = out_r.ack_value;
  assign out_last       = out_r.last;

  // a started transfer always answers with a command beat first
  a_req_starts : assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_op == OP_REQ && (in_is_write || in_length != 5'd0)
    |=> busy && res.kind == KIND_CMD && res.command == CMD_START)
    else $error("request did not issue a start");

  // a held beat inside the block stays put until the output register takes it
  a_res_hold : assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("pending result changed while blocked");

  // buffer writes happen only on item acceptance, never during a read-out
  a_wr_idle : assert property (@(posedge clk) disable iff (!rst_n)
    buf_req.wr_en |-> !busy && in_valid)
    else $error("buffer written while sequencer busy");

endmodule
